// ----- src/rgbwspi_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_pkg
// Shared constants, types and helpers for the RGBW LED strip SPI encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbwspi_pkg;

  // strip geometry
  localparam int LED_COUNT     = 64;
  localparam int LEAD_BYTES    = 0;
  localparam int RESET_BYTES   = 128;
  localparam int LEVEL_MAX     = 255;
  localparam int BYTES_PER_LED = 16;

  localparam int PAYLOAD_END = LEAD_BYTES + LED_COUNT * BYTES_PER_LED;
  localparam int FRAME_TOTAL = PAYLOAD_END + RESET_BYTES;
  localparam int POS_W       = $clog2(FRAME_TOTAL);

  localparam int LEVEL_W     = 16;
  localparam int COLOUR_W    = 8;
  localparam int NUM_COLOURS = 4;

  // level*255/LEVEL_MAX by reciprocal: exact while x*err < 2^SCALE_SHIFT
  localparam int LVL_BITS    = $clog2(LEVEL_MAX + 1);
  localparam int SCALE_SHIFT = COLOUR_W + 2 * LVL_BITS;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SCALE_SHIFT) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX);
  localparam int RECIP_W = SCALE_SHIFT - LVL_BITS + 2;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int X_W    = LEVEL_W + COLOUR_W;
  localparam int PROD_W = X_W + RECIP_W;

  // item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  // colour channel order within an LED
  localparam logic [1:0] CH_WHITE = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_GREEN = 2'd2;
  localparam logic [1:0] CH_BLUE  = 2'd3;

  // line code nibbles
  localparam logic [7:0] HI_ONE    = 8'hC0;
  localparam logic [7:0] HI_ZERO   = 8'h80;
  localparam logic [7:0] LO_ONE    = 8'h0C;
  localparam logic [7:0] LO_ZERO   = 8'h08;
  localparam logic [7:0] BYTE_IDLE = 8'h00;
  localparam logic [7:0] COLOUR_FULL = 8'hFF;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [POS_W-1:0]    pos_t;

  typedef struct packed {
    logic       payload;
    logic       last;
    logic [1:0] chan;
    logic [1:0] pair;
  } byte_meta_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
  } stage_en_t;

  function automatic byte_meta_t decode_pos(pos_t pos, logic last);
    byte_meta_t m;
    pos_t       rel;
    rel       = pos - POS_W'(LEAD_BYTES);
    m.payload = (pos >= POS_W'(LEAD_BYTES)) && (pos < POS_W'(PAYLOAD_END));
    m.last    = last;
    m.chan    = rel[3:2];
    m.pair    = rel[1:0];
    return m;
  endfunction

  function automatic logic [7:0] encode_pair(colour_t c, logic [1:0] pair);
    logic [1:0] bits;
    case (pair)
      2'd0:    bits = c[7:6];
      2'd1:    bits = c[5:4];
      2'd2:    bits = c[3:2];
      2'd3:    bits = c[1:0];
      default: bits = c[1:0];
    endcase
    return (bits[1] ? HI_ONE : HI_ZERO) | (bits[0] ? LO_ONE : LO_ZERO);
  endfunction

endpackage

`default_nettype wire

// ----- src/rgbwspi_cmd_if.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_cmd_if
// Command channel: frame start with four levels, or next-byte request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbwspi_cmd_if;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  rgbwspi_pkg::level_t   red_level;
  rgbwspi_pkg::level_t   green_level;
  rgbwspi_pkg::level_t   blue_level;
  rgbwspi_pkg::level_t   white_level;

  modport source (output valid, mode, red_level, green_level, blue_level, white_level,
                  input ready);
  modport sink   (input valid, mode, red_level, green_level, blue_level, white_level,
                  output ready);
endinterface

`default_nettype wire

// ----- src/rgbwspi_byte_if.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_byte_if
// Byte channel: one SPI frame byte per word, with end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbwspi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       last_of_frame;

  modport source (output valid, spi_byte, last_of_frame, input ready);
  modport sink   (input valid, spi_byte, last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- src/rgbwspi_seq.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_seq
// Frame position counter and frame-active flag, updated per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbwspi_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                mode,
  output logic                keep,
  output rgbwspi_pkg::pos_t   pos,
  output logic                last
);
  import rgbwspi_pkg::*;

  logic active;
  logic active_next;
  pos_t pos_next;

  assign keep = (mode == MODE_START) || active;
  assign last = (pos == POS_W'(FRAME_TOTAL - 1));

  always_comb begin
    active_next = active;
    pos_next    = pos;
    if (accept) begin
      if (mode == MODE_START) begin
        active_next = 1'b1;
        pos_next    = '0;
      end else if (active) begin
        if (last) begin
          active_next = 1'b0;
          pos_next    = '0;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
    end else begin
      active <= active_next;
      pos    <= pos_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/rgbwspi_scale.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_scale
// One colour lane: level*255/LEVEL_MAX with saturation, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbwspi_scale (
  input  logic                     clk,
  input  rgbwspi_pkg::stage_en_t   en,
  input  rgbwspi_pkg::level_t      level,
  output rgbwspi_pkg::colour_t     colour
);
  import rgbwspi_pkg::*;

  logic [X_W-1:0]    x;
  logic              sat2;
  logic [PROD_W-1:0] prod;
  logic              sat3;

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      x    <= {level, 8'h00} - {8'h00, level};
      sat2 <= (level >= LEVEL_W'(LEVEL_MAX));
    end
    if (en.ld3) begin
      prod <= PROD_W'(x) * PROD_W'(RECIP);
      sat3 <= sat2;
    end
  end

  // quotient stays below 255 when not saturated
  assign colour = sat3 ? COLOUR_FULL : prod[SCALE_SHIFT +: COLOUR_W];

endmodule

`default_nettype wire

// ----- src/rgbwspi_enc.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_enc
// Latched colour set and the two-bits-per-byte line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbwspi_enc (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr,
  input  rgbwspi_pkg::colour_t     colour_new [rgbwspi_pkg::NUM_COLOURS],
  input  rgbwspi_pkg::byte_meta_t  meta,
  output logic [7:0]               byte_out
);
  import rgbwspi_pkg::*;

  colour_t colours [NUM_COLOURS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
        colours[i] <= '0;
      end
    end else if (wr) begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
        colours[i] <= colour_new[i];
      end
    end
  end

  assign byte_out = meta.payload ? encode_pair(colours[meta.chan], meta.pair) : BYTE_IDLE;

endmodule

`default_nettype wire

// ----- src/rgbw_led_strip_spi_frame_encoder_top.sv -----
// ----------------------------------------------------------------------------
// rgbw_led_strip_spi_frame_encoder_top
// SPI byte stream generator for a strip of identical RGBW LEDs.
// ----------------------------------------------------------------------------
//  port    dir   role
//  cmd     sink  start frame (four levels) or request next byte
//  stream  src   frame byte plus end-of-frame flag
//
// One word accepted per clock unless a stalled sink backs the pipeline up; a byte
// passes the input reg, level*255 stage, reciprocal multiply stage and output reg.
// The multiply stage of the four scale lanes sets the depth.
// Sync reset clears valid bits, frame state and latched colours.
// With the sink stalled, three more words are taken before cmd.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbw_led_strip_spi_frame_encoder_top (
  input  logic                 clk,
  input  logic                 rst,
  rgbwspi_cmd_if.sink          cmd,
  rgbwspi_byte_if.source       stream
);
  import rgbwspi_pkg::*;

  // stage valids and control
  logic       v1, v2, v3;
  logic       start1, start2, start3;
  logic       oload, leave3, r1, r2, r3;
  logic       accept, keep, last_cur;
  pos_t       pos_cur;
  stage_en_t  en;

  // stage payload
  level_t     lv1 [NUM_COLOURS];
  pos_t       pos1;
  logic       last1;
  byte_meta_t meta2, meta3;
  colour_t    scaled [NUM_COLOURS];
  logic [7:0] byte_enc;

  logic [7:0] spi_byte;
  logic       last_of_frame;
  logic       out_valid;

  assign oload  = !out_valid || stream.ready;
  assign leave3 = v3 && (start3 || oload);
  assign r3     = !v3 || leave3;
  assign r2     = !v2 || r3;
  assign r1     = !v1 || r2;
  assign accept = cmd.valid && r1;
  assign cmd.ready = r1;

  assign en.ld2 = r2;
  assign en.ld3 = r3;

  rgbwspi_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (cmd.mode),
    .keep   (keep),
    .pos    (pos_cur),
    .last   (last_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= accept && keep;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (oload) out_valid <= v3 && !start3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      start1       <= (cmd.mode == MODE_START);
      pos1         <= pos_cur;
      last1        <= last_cur;
      lv1[CH_WHITE] <= cmd.white_level;
      lv1[CH_RED]   <= cmd.red_level;
      lv1[CH_GREEN] <= cmd.green_level;
      lv1[CH_BLUE]  <= cmd.blue_level;
    end
    if (r2) begin
      start2 <= start1;
      meta2  <= decode_pos(pos1, last1);
    end
    if (r3) begin
      start3 <= start2;
      meta3  <= meta2;
    end
    if (oload) begin
      spi_byte      <= byte_enc;
      last_of_frame <= meta3.last;
    end
  end

  for (genvar g = 0; g < NUM_COLOURS; g++) begin : g_lane
    rgbwspi_scale u_scale (
      .clk    (clk),
      .en     (en),
      .level  (lv1[g]),
      .colour (scaled[g])
    );
  end

  // start word retiring from stage 3 latches the colours for words behind it
  rgbwspi_enc u_enc (
    .clk        (clk),
    .rst        (rst),
    .wr         (v3 && start3),
    .colour_new (scaled),
    .meta       (meta3),
    .byte_out   (byte_enc)
  );

  assign stream.valid         = out_valid;
  assign stream.spi_byte      = spi_byte;
  assign stream.last_of_frame = last_of_frame;

endmodule

`default_nettype wire

// ----- src/rgbwspi_check.sv -----
// ----------------------------------------------------------------------------
// rgbwspi_check
// Port-level checks on the encoder's byte stream and cmd.ready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbwspi_check (
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       stream_valid,
  input logic       stream_ready,
  input logic [7:0] spi_byte,
  input logic       last_of_frame
);
  import rgbwspi_pkg::*;

  // encoded byte is 1x00_1x00
  localparam logic [7:0] FORM_MASK = 8'hBB;
  localparam logic [7:0] FORM_BITS = 8'h88;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    stream_valid && !stream_ready |=>
      stream_valid && $stable(spi_byte) && $stable(last_of_frame))
    else $error("stalled byte word changed");

  a_form: assert property (@(posedge clk) disable iff (rst)
    stream_valid |-> (spi_byte == BYTE_IDLE) || ((spi_byte & FORM_MASK) == FORM_BITS))
    else $error("byte is neither idle nor line coded");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    stream_valid && last_of_frame |-> spi_byte == BYTE_IDLE)
    else $error("end of frame on a data byte");

  a_reset: assert property (@(posedge clk)
    rst |=> !stream_valid && cmd_ready)
    else $error("pipeline not empty after reset");

endmodule

bind rgbw_led_strip_spi_frame_encoder_top rgbwspi_check u_check (
  .clk           (clk),
  .rst           (rst),
  .cmd_ready     (cmd.ready),
  .stream_valid  (stream.valid),
  .stream_ready  (stream.ready),
  .spi_byte      (stream.spi_byte),
  .last_of_frame (stream.last_of_frame)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGBW strip SPI frame encoder: drives start and
// next-byte words with random idling on both channels, predicts every frame
// byte in a scoreboard and compares the byte stream word by word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbwspi_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] spi_byte;
    logic       last;
  } frame_word_t;

  // predicted strip state plus the queue of bytes still owed by the block
  class frame_scoreboard;
    colour_t     colours[NUM_COLOURS];
    int          position;
    bit          active;
    frame_word_t owed[$];
    int          errors;

    function new();
      foreach (colours[i]) colours[i] = '0;
      position     = 0;
      active       = 0;
      errors       = 0;
    endfunction

    function colour_t to_colour(level_t lv);
      int unsigned l;
      l = lv;
      if (l >= LEVEL_MAX) return COLOUR_FULL;
      return colour_t'((l * 255) / LEVEL_MAX);
    endfunction

    function logic [7:0] byte_at(int pos);
      int         rel;
      colour_t    c;
      logic [1:0] duo;
      if (pos < LEAD_BYTES || pos >= PAYLOAD_END) return BYTE_IDLE;
      rel = (pos - LEAD_BYTES) % BYTES_PER_LED;
      c   = colours[rel / 4];
      // MSB-first: pair 0 holds bits 7:6
      duo = 2'(c >> (6 - 2 * (rel % 4)));
      return (duo[1] ? HI_ONE : HI_ZERO) | (duo[0] ? LO_ONE : LO_ZERO);
    endfunction

    // returns 1 when the word does something (start, or byte produced)
    function bit note_cmd(logic mode, level_t r, level_t g, level_t b, level_t w);
      frame_word_t fw;
      if (mode == MODE_START) begin
        colours[CH_WHITE] = to_colour(w);
        colours[CH_RED]   = to_colour(r);
        colours[CH_GREEN] = to_colour(g);
        colours[CH_BLUE]  = to_colour(b);
        position = 0;
        active   = 1;
        return 1;
      end
      if (!active) return 0;
      fw.spi_byte = byte_at(position);
      fw.last     = (position + 1 >= FRAME_TOTAL);
      owed.push_back(fw);
      if (fw.last) begin
        active   = 0;
        position = 0;
      end else begin
        position++;
      end
      return 1;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] got_byte, logic got_last);
      frame_word_t fw;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last=%0b", got_byte, got_last));
        return;
      end
      fw = owed.pop_front();
      if (got_byte !== fw.spi_byte)
        report_mismatch($sformatf("spi_byte %02h, want %02h", got_byte, fw.spi_byte));
      if (got_last !== fw.last)
        report_mismatch($sformatf("last_of_frame %0b, want %0b", got_last, fw.last));
    endtask

    function int owed_count();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   words_sent;

  frame_scoreboard sb = new();

  rgbwspi_cmd_if  cmd_bus();
  rgbwspi_byte_if byte_bus();

  rgbw_led_strip_spi_frame_encoder_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .stream (byte_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // sink side: random stalls unless in the steady stretch
  initial begin
    byte_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      byte_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_bus.valid && byte_bus.ready)
      sb.check_byte(byte_bus.spi_byte, byte_bus.last_of_frame);
  end

  function automatic level_t rand_level();
    case ($urandom_range(0, 3))
      0: return level_t'($urandom);
      1: return level_t'($urandom_range(0, LEVEL_MAX + 8));
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return level_t'(LEVEL_MAX - 1);
          2:       return level_t'(LEVEL_MAX);
          default: return '1;
        endcase
      end
      default: return level_t'($urandom_range(0, LEVEL_MAX));
    endcase
  endfunction

  task automatic send_word(logic mode, level_t r, level_t g, level_t b, level_t w);
    while (!steady && $urandom_range(0, 99) < 21) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.mode        <= mode;
    cmd_bus.red_level   <= r;
    cmd_bus.green_level <= g;
    cmd_bus.blue_level  <= b;
    cmd_bus.white_level <= w;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    void'(sb.note_cmd(mode, r, g, b, w));
    words_sent++;
  endtask

  task automatic send_next();
    send_word(MODE_NEXT, level_t'($urandom), level_t'($urandom),
              level_t'($urandom), level_t'($urandom));
  endtask

  task automatic send_start();
    send_word(MODE_START, rand_level(), rand_level(), rand_level(), rand_level());
  endtask

  // hold the command side until the stream has caught up
  task automatic drain_stream();
    cmd_bus.valid <= 1'b0;
    while (sb.owed_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int seq_idx;
    int span;
    rst                 <= 1'b1;
    steady              = 1'b0;
    words_sent          = 0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.mode        <= MODE_NEXT;
    cmd_bus.red_level   <= '0;
    cmd_bus.green_level <= '0;
    cmd_bus.blue_level  <= '0;
    cmd_bus.white_level <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // requests with no frame running are dropped
    send_next();
    send_next();
    // level extremes: zero, full scale, just under and at LEVEL_MAX
    send_word(MODE_START, 16'hFFFF, level_t'(LEVEL_MAX - 1), level_t'(LEVEL_MAX), 16'h0000);
    repeat (BYTES_PER_LED) send_next();
    // restart mid-frame with alternating bit patterns
    send_word(MODE_START, 16'h0055, level_t'(LEVEL_MAX + 1), 16'h0001, 16'h00AA);
    repeat (4) send_next();

    seq_idx = 0;
    while (words_sent < RANDOM_WORDS) begin
      steady = (seq_idx >= 4 && seq_idx < 8);
      if (seq_idx == 2) drain_stream();
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_next();
      send_start();
      // frames cut short at random lengths by the next start
      span = $urandom_range(1, 48);
      repeat (span) send_next();
      seq_idx++;
    end
    steady = 1'b0;

    drain_stream();
    if (sb.owed_count() != 0) sb.report_mismatch("bytes never delivered");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- rgbw_led_strip_spi_frame_encoder_top.f -----
src/rgbwspi_pkg.sv
src/rgbwspi_cmd_if.sv
src/rgbwspi_byte_if.sv
src/rgbwspi_seq.sv
src/rgbwspi_scale.sv
src/rgbwspi_enc.sv
src/rgbw_led_strip_spi_frame_encoder_top.sv
src/rgbwspi_check.sv
sim/testbench.sv
